// ===== sv/pdd_pkg.sv =====
// ----------------------------------------------------------------------------
// pdd_pkg - shared types and constants of the polyline delta decoder
// Request and response payloads, the classified character and the
// coordinate helpers used by the decode stage.
// ----------------------------------------------------------------------------
package pdd_pkg;

   // Width of the accumulator and of the running sums.
   localparam int CoordWidth = 32;

   localparam logic [7:0] CharBias  = 8'd63;
   localparam logic [7:0] MoreMark  = 8'h20;
   localparam logic [7:0] MoreLimit = CharBias + MoreMark;
   localparam int         ChunkBits = 5;
   localparam logic [5:0] ShiftFull = 6'd63;

   // Entries of the queue between front and back.
   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   typedef logic [CoordWidth-1:0] coord_type;
   typedef logic [5:0]            shift_type;
   typedef logic [ChunkBits-1:0]  chunk_type;

   typedef struct packed {
      logic [7:0] code_char;
      logic       first_of_string;
   } req_type;

   typedef struct packed {
      logic signed [31:0] latitude;
      logic signed [31:0] longitude;
   } rsp_type;

   // Character after classification.
   typedef struct packed {
      logic      first;
      logic      more;
      chunk_type chunk;
   } item_type;

   // Undo the zigzag sign mapping.
   function automatic coord_type unzigzag(input coord_type v);
      coord_type half;
      half = {v[CoordWidth-1], v[CoordWidth-1:1]};
      if (v[0]) begin
         half = ~half;
      end
      return half;
   endfunction

   // Sign-extend or truncate a sum to the 32-bit output.
   function automatic logic signed [31:0] to_out(input coord_type v);
      return 32'(signed'(v));
   endfunction

endpackage

// ===== sv/pdd_front.sv =====
// ----------------------------------------------------------------------------
// pdd_front - request intake and character classification
// Registers each request as a chunk, a continuation mark and a start flag.
// ----------------------------------------------------------------------------
module pdd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pdd_pkg::req_type  req_data,
   output logic              item_valid,
   input  logic              item_ready,
   output pdd_pkg::item_type item_data
);

   logic              valid_ff;
   logic              valid_in;
   pdd_pkg::item_type item_ff;
   pdd_pkg::item_type item_in;
   logic              take;
   logic [7:0]        diff;

   assign req_ready  = !valid_ff || item_ready;
   assign take       = req_valid && req_ready;
   assign item_valid = valid_ff;
   assign item_data  = item_ff;

   always_comb begin
      diff            = req_data.code_char - pdd_pkg::CharBias;
      item_in.first   = req_data.first_of_string;
      item_in.more    = req_data.code_char >= pdd_pkg::MoreLimit;
      item_in.chunk   = diff[pdd_pkg::ChunkBits-1:0];
      if (take) begin
         valid_in = 1'b1;
      end else if (item_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

endmodule

// ===== sv/pdd_queue.sv =====
// ----------------------------------------------------------------------------
// pdd_queue - short queue of classified characters
// Decouples the intake stage from the decode stage.
// ----------------------------------------------------------------------------
module pdd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  pdd_pkg::item_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output pdd_pkg::item_type out_data
);

   pdd_pkg::item_type                 slot_ff [pdd_pkg::QueueDepth];
   logic [pdd_pkg::QueuePtrW-1:0]     wr_ptr_ff;
   logic [pdd_pkg::QueuePtrW-1:0]     wr_ptr_in;
   logic [pdd_pkg::QueuePtrW-1:0]     rd_ptr_ff;
   logic [pdd_pkg::QueuePtrW-1:0]     rd_ptr_in;
   logic [pdd_pkg::QueueCntW-1:0]     count_ff;
   logic [pdd_pkg::QueueCntW-1:0]     count_in;
   logic                              push;
   logic                              pop;

   assign in_ready  = count_ff != pdd_pkg::QueueCntW'(pdd_pkg::QueueDepth);
   assign out_valid = count_ff != '0;
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         if (wr_ptr_ff == pdd_pkg::QueuePtrW'(pdd_pkg::QueueDepth - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + 1'b1;
         end
      end
      if (pop) begin
         if (rd_ptr_ff == pdd_pkg::QueuePtrW'(pdd_pkg::QueueDepth - 1)) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = rd_ptr_ff + 1'b1;
         end
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= pdd_pkg::QueueCntW'(pdd_pkg::QueueDepth))
      else $error("queue count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue push lost");

   assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue pop lost");

endmodule

// ===== sv/pdd_back.sv =====
// ----------------------------------------------------------------------------
// pdd_back - chunk gathering, zigzag decode and running sums
// Consumes one classified character per cycle while no point waits on rsp_ready, and registers each point.
// ----------------------------------------------------------------------------
module pdd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   output logic              item_ready,
   input  pdd_pkg::item_type item_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pdd_pkg::rsp_type  rsp_data
);

   pdd_pkg::coord_type acc_ff;
   pdd_pkg::coord_type acc_in;
   pdd_pkg::shift_type shift_ff;
   pdd_pkg::shift_type shift_in;
   logic               on_lng_ff;
   logic               on_lng_in;
   pdd_pkg::coord_type lat_sum_ff;
   pdd_pkg::coord_type lat_sum_in;
   pdd_pkg::coord_type lng_sum_ff;
   pdd_pkg::coord_type lng_sum_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   pdd_pkg::rsp_type   rsp_data_ff;
   pdd_pkg::rsp_type   rsp_data_in;

   logic               fire;
   pdd_pkg::coord_type base_acc;
   pdd_pkg::shift_type base_shift;
   logic               base_lng;
   pdd_pkg::coord_type base_lat;
   pdd_pkg::coord_type base_lng_sum;
   logic               gather;
   pdd_pkg::coord_type new_acc;
   logic [6:0]         shift_sum;
   pdd_pkg::shift_type next_shift;
   pdd_pkg::coord_type delta;
   pdd_pkg::coord_type lat_add;
   pdd_pkg::coord_type lng_add;

   assign item_ready = !rsp_valid_ff || rsp_ready;
   assign fire       = item_valid && item_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      // A start flag clears everything before this character.
      base_acc     = item_data.first ? '0 : acc_ff;
      base_shift   = item_data.first ? '0 : shift_ff;
      base_lng     = item_data.first ? 1'b0 : on_lng_ff;
      base_lat     = item_data.first ? '0 : lat_sum_ff;
      base_lng_sum = item_data.first ? '0 : lng_sum_ff;

      gather  = (base_shift != pdd_pkg::ShiftFull)
                && (7'(base_shift) < 7'(pdd_pkg::CoordWidth));
      new_acc = gather
                ? base_acc | (pdd_pkg::CoordWidth'(item_data.chunk) << base_shift)
                : base_acc;

      shift_sum  = 7'(base_shift) + 7'(pdd_pkg::ChunkBits);
      next_shift = (shift_sum > 7'(pdd_pkg::ShiftFull)) ? pdd_pkg::ShiftFull
                                                        : shift_sum[5:0];

      delta   = pdd_pkg::unzigzag(new_acc);
      lat_add = base_lat + delta;
      lng_add = base_lng_sum + delta;

      acc_in       = acc_ff;
      shift_in     = shift_ff;
      on_lng_in    = on_lng_ff;
      lat_sum_in   = lat_sum_ff;
      lng_sum_in   = lng_sum_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (fire) begin
         lat_sum_in = base_lat;
         lng_sum_in = base_lng_sum;
         on_lng_in  = base_lng;
         if (item_data.more) begin
            acc_in   = new_acc;
            shift_in = next_shift;
         end else begin
            acc_in   = '0;
            shift_in = '0;
            if (!base_lng) begin
               lat_sum_in = lat_add;
               on_lng_in  = 1'b1;
            end else begin
               lng_sum_in           = lng_add;
               on_lng_in            = 1'b0;
               rsp_valid_in         = 1'b1;
               rsp_data_in.latitude  = pdd_pkg::to_out(base_lat);
               rsp_data_in.longitude = pdd_pkg::to_out(lng_add);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         shift_ff     <= '0;
         on_lng_ff    <= 1'b0;
         lat_sum_ff   <= '0;
         lng_sum_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         shift_ff     <= shift_in;
         on_lng_ff    <= on_lng_in;
         lat_sum_ff   <= lat_sum_in;
         lng_sum_ff   <= lng_sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      fire && item_data.more |=> shift_ff != '0)
      else $error("continued value did not advance chunk position");

   assert property (@(posedge clock) disable iff (reset)
      fire && !item_data.more |=> shift_ff == '0 && acc_ff == '0)
      else $error("accumulator not cleared at value end");

   assert property (@(posedge clock) disable iff (reset)
      fire && !item_data.more && item_data.first
      |=> on_lng_ff && !$past(rsp_valid_ff && !rsp_ready) |-> !rsp_valid_ff)
      else $error("first value of a string emitted a point");

   assert property (@(posedge clock) disable iff (reset)
      fire && !item_data.more && on_lng_ff && !item_data.first
      |=> rsp_valid_ff && !on_lng_ff)
      else $error("longitude end did not emit a point");

endmodule

// ===== sv/polyline_delta_decoder_top.sv =====
// ----------------------------------------------------------------------------
// polyline_delta_decoder_top - encoded polyline decoder
// Decodes one polyline character per cycle into running latitude and
// longitude sums and emits a point after each longitude.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one character of the encoded string per request, with
//   first_of_string set on the first character of each string; that flag
//   clears the chunk state, the lat/lng toggle and both sums before the
//   character is decoded.
//   rsp_* carries one point (latitude, longitude) each time a longitude
//   value completes; sums are integers in units of ten to minus precision
//   and wrap modulo 2^32.
// Path: the character ending a longitude passes the intake register, the
//   queue and the decode stage, which feeds the response register that
//   drives rsp_valid.
// Throughput: one character per cycle while no point stalls on rsp_ready,
//   set by the decode stage (chunk OR, zigzag, a 32-bit add per sum).
// Reset: synchronous; clears all decode state, empties the queue and drops
//   rsp_valid.
// Stall: while rsp_ready is low the response register holds its point, the
//   decode stage stops, the two-entry queue and intake register fill, then req_ready drops.
// ----------------------------------------------------------------------------
module polyline_delta_decoder_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pdd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pdd_pkg::rsp_type rsp_data
);

   // Intake stage to queue.
   logic              front_valid;
   logic              front_ready;
   pdd_pkg::item_type front_item;

   // Queue to decode stage.
   logic              back_valid;
   logic              back_ready;
   pdd_pkg::item_type back_item;

   // Classify each character: chunk, continuation mark, start flag.
   pdd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .item_valid (front_valid),
      .item_ready (front_ready),
      .item_data  (front_item)
   );

   // Hold classified characters so intake and decode stall independently.
   pdd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_item),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_data  (back_item)
   );

   // Gather chunks, undo zigzag, advance sums and register each point.
   pdd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (back_valid),
      .item_ready (back_ready),
      .item_data  (back_item),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
